// ----- hdl/gcd_pkg.sv -----
// Shared constants, types and functions for the great-circle distance pipeline.
package gcd_pkg;

    localparam int CORDIC_N = 24;
    localparam int SQRT_N   = 31;
    localparam int LAT      = 2 * CORDIC_N + SQRT_N + 10;

    localparam int W   = 34;
    localparam int AW  = 31;
    localparam int IDX = 5;
    localparam int SQW = 62;

    localparam logic signed [W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [W-1:0] ONE_Q30     = 34'sd1073741824;

    localparam logic signed [AW-1:0] DEG_FULL    = 31'sd754974720;
    localparam logic signed [AW-1:0] DEG_HALF    = 31'sd377487360;
    localparam logic signed [AW-1:0] DEG_QUARTER = 31'sd188743680;

    localparam logic [34:0] DEG_TO_RAD = 35'd19190098069;
    localparam logic [16:0] D2R_HI     = DEG_TO_RAD[34:18];
    localparam logic [17:0] D2R_LO     = DEG_TO_RAD[17:0];

    localparam logic [13:0] DIAMETER_KM = 14'd12742;

    localparam logic signed [W-1:0] ATAN_LOW [11] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576
    };

    typedef struct packed {
        logic           en;
        logic           vectoring;
        logic [IDX-1:0] idx;
    } t_cell_ctl;

    function automatic logic signed [W-1:0] atan_entry(input logic [IDX-1:0] i);
        logic signed [W-1:0] v;
        v = '0;
        if (i <= 5'd10) begin
            v = ATAN_LOW[i[3:0]];
        end else if (i <= 5'd30) begin
            v = W'(1) << (5'd30 - i);
        end
        return v;
    endfunction

    function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b;
        p = p + (2*W)'(64'sd536870912);
        return W'(p >>> 30);
    endfunction

endpackage

// ----- hdl/gcd_cordic_cell.sv -----
// One CORDIC micro-rotation cell, rotation or vectoring mode.
module gcd_cordic_cell (
    input  logic                         i_clk,
    input  gcd_pkg::t_cell_ctl           i_ctl,
    input  logic signed [gcd_pkg::W-1:0] i_x,
    input  logic signed [gcd_pkg::W-1:0] i_y,
    input  logic signed [gcd_pkg::W-1:0] i_z,
    output logic signed [gcd_pkg::W-1:0] o_x,
    output logic signed [gcd_pkg::W-1:0] o_y,
    output logic signed [gcd_pkg::W-1:0] o_z
);
    logic signed [gcd_pkg::W-1:0] r_x, r_y, r_z;
    logic signed [gcd_pkg::W-1:0] n_x, n_y, n_z;
    logic signed [gcd_pkg::W-1:0] dx, dy, at;
    logic                         cw;

    always_comb begin
        dx = i_y >>> i_ctl.idx;
        dy = i_x >>> i_ctl.idx;
        at = gcd_pkg::atan_entry(i_ctl.idx);
        cw = i_ctl.vectoring ? i_y[gcd_pkg::W-1] : !i_z[gcd_pkg::W-1];
        if (cw) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - at;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ----- hdl/gcd_sqrt_cell.sv -----
// One step of the bit-serial square root.
module gcd_sqrt_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [gcd_pkg::IDX-1:0]    i_idx,
    input  logic [gcd_pkg::SQW-1:0]    i_n,
    input  logic [gcd_pkg::SQW-1:0]    i_res,
    output logic [gcd_pkg::SQW-1:0]    o_n,
    output logic [gcd_pkg::SQW-1:0]    o_res
);
    logic [gcd_pkg::SQW-1:0] r_n, r_res;
    logic [gcd_pkg::SQW-1:0] n_n, n_res;
    logic [gcd_pkg::SQW-1:0] bitv, trial;

    always_comb begin
        bitv  = gcd_pkg::SQW'(1) << (6'd60 - {i_idx, 1'b0});
        trial = i_res + bitv;
        if (i_n >= trial) begin
            n_n   = i_n - trial;
            n_res = (i_res >> 1) + bitv;
        end else begin
            n_n   = i_n;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_res <= n_res;
        end
    end

    assign o_n   = r_n;
    assign o_res = r_res;
endmodule

// ----- hdl/gcd_prep.sv -----
// Angle reduction, quadrant fold and degree-to-radian conversion.
module gcd_prep (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [gcd_pkg::AW-1:0] i_ang,
    output logic signed [gcd_pkg::W-1:0]  o_rad,
    output logic                          o_neg
);
    logic signed [gcd_pkg::AW-1:0] red, fold, r_fold;
    logic                          fneg, r_neg1, r_neg2, r_neg3, r_sign2;
    logic [gcd_pkg::AW-1:0]        mag;
    logic [44:0]                   r_ph;
    logic [45:0]                   r_pl;
    logic [63:0]                   sum;
    logic signed [gcd_pkg::W-1:0]  q, r_rad;

    always_comb begin
        red = i_ang;
        if (i_ang >= gcd_pkg::DEG_HALF) begin
            red = i_ang - gcd_pkg::DEG_FULL;
        end else if (i_ang < -gcd_pkg::DEG_HALF) begin
            red = i_ang + gcd_pkg::DEG_FULL;
        end
        fold = red;
        fneg = 1'b0;
        if (red > gcd_pkg::DEG_QUARTER) begin
            fold = red - gcd_pkg::DEG_HALF;
            fneg = 1'b1;
        end else if (red < -gcd_pkg::DEG_QUARTER) begin
            fold = red + gcd_pkg::DEG_HALF;
            fneg = 1'b1;
        end
        mag = r_fold[gcd_pkg::AW-1] ? gcd_pkg::AW'(-r_fold) : gcd_pkg::AW'(r_fold);
        sum = {1'b0, r_ph, 18'd0} + 64'(r_pl) + 64'd1073741824;
        q   = gcd_pkg::W'({31'd0, sum[63:31]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold  <= fold;
            r_neg1  <= fneg;
            r_ph    <= 45'(mag[27:0] * gcd_pkg::D2R_HI);
            r_pl    <= 46'(mag[27:0] * gcd_pkg::D2R_LO);
            r_sign2 <= r_fold[gcd_pkg::AW-1];
            r_neg2  <= r_neg1;
            r_rad   <= r_sign2 ? -q : q;
            r_neg3  <= r_neg2;
        end
    end

    assign o_rad = r_rad;
    assign o_neg = r_neg3;
endmodule

// ----- hdl/great_circle_distance_top.sv -----
// Haversine great-circle distance pipeline, top level.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Path: reduction and radians, 24 rotation cells, products, 31 square-root cells,
// 24 vectoring cells, scaling into the output register.
// Reset clears the valid pipeline only; data registers are not reset.
module great_circle_distance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [27:0] i_first_latitude,
    input  logic signed [28:0] i_first_longitude,
    input  logic signed [27:0] i_second_latitude,
    input  logic signed [28:0] i_second_longitude,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_distance_km
);
    localparam int N = gcd_pkg::CORDIC_N;
    localparam int S = gcd_pkg::SQRT_N;
    localparam int L = gcd_pkg::LAT;

    logic                          en;
    logic [L-1:0]                  r_vld;
    logic signed [gcd_pkg::AW-1:0] r_ang [4];
    logic signed [gcd_pkg::W-1:0]  prep_rad [4];
    logic [3:0]                    prep_neg;
    logic [3:0]                    r_neg_line [N];
    logic signed [gcd_pkg::W-1:0]  rx [4][N+1];
    logic signed [gcd_pkg::W-1:0]  ry [4][N+1];
    logic signed [gcd_pkg::W-1:0]  rz [4][N+1];
    logic signed [gcd_pkg::W-1:0]  r_u, r_v, r_c1, r_c2;
    logic signed [gcd_pkg::W-1:0]  r_uu, r_vv, r_cc, r_uu3, r_w, r_sum, r_h, r_t;
    logic [gcd_pkg::SQW-1:0]       sn [2][S+1];
    logic [gcd_pkg::SQW-1:0]       sr [2][S+1];
    logic signed [gcd_pkg::W-1:0]  vx [N+1];
    logic signed [gcd_pkg::W-1:0]  vy [N+1];
    logic signed [gcd_pkg::W-1:0]  vz [N+1];
    logic [30:0]                   ang;
    logic [44:0]                   dprod;
    logic [30:0]                   r_dist;
    logic signed [gcd_pkg::W-1:0]  rad_abs;

    assign en      = !(r_vld[L-1] && i_stall);
    assign o_stall = r_vld[L-1] && i_stall;
    assign o_valid = r_vld[L-1];
    assign o_distance_km = r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= gcd_pkg::AW'(i_second_latitude) - gcd_pkg::AW'(i_first_latitude);
            r_ang[1] <= gcd_pkg::AW'(i_second_longitude) - gcd_pkg::AW'(i_first_longitude);
            r_ang[2] <= gcd_pkg::AW'(i_first_latitude) <<< 1;
            r_ang[3] <= gcd_pkg::AW'(i_second_latitude) <<< 1;
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        gcd_prep u_prep (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ang (r_ang[l]),
            .o_rad (prep_rad[l]),
            .o_neg (prep_neg[l])
        );
        assign rx[l][0] = gcd_pkg::CORDIC_GAIN;
        assign ry[l][0] = '0;
        assign rz[l][0] = prep_rad[l];
        for (genvar k = 0; k < N; k++) begin : g_rot
            gcd_pkg::t_cell_ctl ctl;
            assign ctl = '{en: en, vectoring: 1'b0, idx: gcd_pkg::IDX'(k)};
            gcd_cordic_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (ctl),
                .i_x   (rx[l][k]),
                .i_y   (ry[l][k]),
                .i_z   (rz[l][k]),
                .o_x   (rx[l][k+1]),
                .o_y   (ry[l][k+1]),
                .o_z   (rz[l][k+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg_line[0] <= prep_neg;
            for (int k = 1; k < N; k++) begin
                r_neg_line[k] <= r_neg_line[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u   <= r_neg_line[N-1][0] ? -ry[0][N] : ry[0][N];
            r_v   <= r_neg_line[N-1][1] ? -ry[1][N] : ry[1][N];
            r_c1  <= r_neg_line[N-1][2] ? -rx[2][N] : rx[2][N];
            r_c2  <= r_neg_line[N-1][3] ? -rx[3][N] : rx[3][N];
            r_uu  <= gcd_pkg::mulq(r_u, r_u);
            r_vv  <= gcd_pkg::mulq(r_v, r_v);
            r_cc  <= gcd_pkg::mulq(r_c1, r_c2);
            r_uu3 <= r_uu;
            r_w   <= gcd_pkg::mulq(r_cc, r_vv);
            r_sum <= r_uu3 + r_w;
            if (r_sum > gcd_pkg::ONE_Q30) begin
                r_h <= gcd_pkg::ONE_Q30;
                r_t <= '0;
            end else if (r_sum[gcd_pkg::W-1]) begin
                r_h <= '0;
                r_t <= gcd_pkg::ONE_Q30;
            end else begin
                r_h <= r_sum;
                r_t <= gcd_pkg::ONE_Q30 - r_sum;
            end
        end
    end

    assign sn[0][0] = gcd_pkg::SQW'(r_h[30:0]) << 30;
    assign sn[1][0] = gcd_pkg::SQW'(r_t[30:0]) << 30;
    assign sr[0][0] = '0;
    assign sr[1][0] = '0;

    for (genvar l = 0; l < 2; l++) begin : g_sq
        for (genvar k = 0; k < S; k++) begin : g_step
            gcd_sqrt_cell u_sq (
                .i_clk (i_clk),
                .i_en  (en),
                .i_idx (gcd_pkg::IDX'(k)),
                .i_n   (sn[l][k]),
                .i_res (sr[l][k]),
                .o_n   (sn[l][k+1]),
                .o_res (sr[l][k+1])
            );
        end
    end

    assign vx[0] = gcd_pkg::W'(sr[1][S][30:0]);
    assign vy[0] = gcd_pkg::W'(sr[0][S][30:0]);
    assign vz[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_vec
        gcd_pkg::t_cell_ctl ctl;
        assign ctl = '{en: en, vectoring: 1'b1, idx: gcd_pkg::IDX'(k)};
        gcd_cordic_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_x   (vx[k]),
            .i_y   (vy[k]),
            .i_z   (vz[k]),
            .o_x   (vx[k+1]),
            .o_y   (vy[k+1]),
            .o_z   (vz[k+1])
        );
    end

    always_comb begin
        ang   = vz[N][gcd_pkg::W-1] ? '0 : vz[N][30:0];
        dprod = 45'(ang) * 45'(gcd_pkg::DIAMETER_KM) + 45'd8192;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= dprod[44:14];
        end
    end

    assign rad_abs = prep_rad[0][gcd_pkg::W-1] ? -prep_rad[0] : prep_rad[0];

    a_h_t_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N+8] |-> (r_h + r_t == gcd_pkg::ONE_Q30))
        else $error("haversine term and complement do not sum to one");

    a_rad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (rad_abs <= 34'sd1686629714))
        else $error("converted angle beyond a quarter turn");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule

// ----- test/great_circle_distance_top_test.sv -----
// Self-checking testbench for the haversine great-circle distance pipeline.
`timescale 1ns / 100ps

module great_circle_distance_top_test;

    localparam int STAGES    = 24;
    localparam longint ONE   = 64'sd1 << 30;
    localparam longint FULL  = 64'sd360 << 21;
    localparam longint HALF  = 64'sd180 << 21;
    localparam longint QUART = 64'sd90 << 21;
    localparam longint LAT_MAX = 94371840;
    localparam longint LON_MAX = 188743680;
    localparam int LIMIT     = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [27:0] i_first_latitude;
    logic signed [28:0] i_first_longitude;
    logic signed [27:0] i_second_latitude;
    logic signed [28:0] i_second_longitude;
    logic               o_valid;
    logic               i_stall;
    logic [30:0]        o_distance_km;

    logic [30:0] distance_queue[$];
    int          mismatches;
    int          requests;
    int          results;
    int          cycles;
    bit          calm;

    great_circle_distance_top dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan(int i);
        longint low[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i <= 10) return low[i];
        if (i <= 30) return 64'sd1 << (30 - i);
        return 0;
    endfunction

    function automatic longint mul30(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint root30(longint a);
        logic [63:0] n, res, b;
        n = 64'(a) << 30;
        res = 0;
        b = 64'd1 << 60;
        for (int k = 0; k < 31; k++) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    task automatic rotate(input longint ang, output longint sn, output longint cs);
        longint r, mag, rad, x, y, z, dx, dy;
        logic [127:0] p;
        bit flip;
        flip = 0;
        r = ang % FULL;
        if (r < 0) r += FULL;
        if (r >= HALF) r -= FULL;
        if (r > QUART) begin
            r -= HALF;
            flip = 1;
        end else if (r < -QUART) begin
            r += HALF;
            flip = 1;
        end
        mag = r < 0 ? -r : r;
        p = 128'(mag) * 128'd19190098069 + (128'd1 << 30);
        rad = longint'(p >> 31);
        if (r < 0) rad = -rad;
        x = 652032874;
        y = 0;
        z = rad;
        for (int i = 0; i < STAGES; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan(i);
            end else begin
                x += dx; y -= dy; z += arctan(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    task automatic predict_distance(input longint la1, lo1, la2, lo2, output logic [30:0] d);
        longint u, v, c1, c2, unused, h, s, t, x, y, z, dx, dy;
        rotate(la2 - la1, u, unused);
        rotate(lo2 - lo1, v, unused);
        rotate(la1 * 2, unused, c1);
        rotate(la2 * 2, unused, c2);
        h = mul30(u, u) + mul30(mul30(c1, c2), mul30(v, v));
        if (h > ONE) h = ONE;
        if (h < 0) h = 0;
        s = root30(h);
        t = root30(ONE - h);
        x = t;
        y = s;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y < 0) begin
                x -= dx; y += dy; z -= arctan(i);
            end else begin
                x += dx; y -= dy; z += arctan(i);
            end
        end
        if (z < 0) z = 0;
        d = 31'((z * 12742 + (64'sd1 << 13)) >>> 14);
    endtask

    task automatic report(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    task automatic send_request(input longint la1, lo1, la2, lo2);
        logic [30:0] d;
        if (!calm && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 35) @(posedge i_clk);
        end
        predict_distance(longint'(signed'(28'(la1))), longint'(signed'(29'(lo1))),
                         longint'(signed'(28'(la2))), longint'(signed'(29'(lo2))), d);
        i_valid            <= 1'b1;
        i_first_latitude   <= 28'(la1);
        i_first_longitude  <= 29'(lo1);
        i_second_latitude  <= 28'(la2);
        i_second_longitude <= 29'(lo2);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        distance_queue.insert(distance_queue.size(), d);
        requests++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= !calm && ($urandom_range(99) < 35);
            if (o_valid && !i_stall) begin
                results++;
                if (distance_queue.size() == 0) begin
                    report("result with nothing expected");
                end else if (o_distance_km !== distance_queue[0]) begin
                    report($sformatf("distance got %0d want %0d",
                                     o_distance_km, distance_queue[0]));
                    void'(distance_queue.pop_front());
                end else begin
                    void'(distance_queue.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint rand_range(longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    task automatic test_extremes();
        send_request(0, 0, 0, 0);
        send_request(LAT_MAX, 0, -LAT_MAX, 0);
        send_request(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_request(0, -LON_MAX, 0, LON_MAX);
        send_request(0, 0, 0, LON_MAX);
        send_request(LAT_MAX, 12345, LAT_MAX, -777777);
        send_request(1, 0, 0, 0);
        send_request(0, 0, 0, 1);
        send_request(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
        send_request((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
        send_request(45 << 20, 30 << 20, -(45 << 20), -(150 << 20));
        send_request(10 << 20, 20 << 20, -(10 << 20), -(160 << 20));
        send_request(0, 90 << 20, 0, -(90 << 20));
    endtask

    task automatic test_antipodes();
        longint la, lo;
        for (int k = 0; k < 12; k++) begin
            la = rand_range(LAT_MAX);
            lo = rand_range(LON_MAX);
            send_request(la, lo, -la, lo + (lo < 0 ? LON_MAX : -LON_MAX)
                         + rand_range(3));
        end
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            calm = (k >= n / 3) && (k < n / 3 + 150);
            if ($urandom_range(9) == 0)
                send_request($urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(3) == 0)
                send_request(rand_range(LAT_MAX), rand_range(LON_MAX),
                             rand_range(LAT_MAX) >>> 8, rand_range(LON_MAX) >>> 8);
            else
                send_request(rand_range(LAT_MAX), rand_range(LON_MAX),
                             rand_range(LAT_MAX), rand_range(LON_MAX));
        end
        calm = 0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (distance_queue.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_first_latitude = '0;
        i_first_longitude = '0;
        i_second_latitude = '0;
        i_second_longitude = '0;
        calm = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_antipodes();
        drain();
        test_random(1425);
        drain();
        repeat (200) @(posedge i_clk);
        $display("Checked %0d distance requests, %0d results, incl. extremes and antipodes.",
                 requests, results);
        if (mismatches == 0 && distance_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
